### hw/rtl/windowed_cumulative_trapezoid_unit_defines.svh
// assertion macros for the trapezoid unit rtl
// no dependencies; included by wct_ctrl, the only file that carries concurrent checks
`ifndef WINDOWED_CUMULATIVE_TRAPEZOID_UNIT_DEFINES_SVH
`define WINDOWED_CUMULATIVE_TRAPEZOID_UNIT_DEFINES_SVH

// same-cycle implication
`define WCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/wct_pkg.sv
// shared types, constants and helpers for the windowed trapezoid unit
// no dependencies; used by all rtl files of the block but wct_ram
`timescale 1ns / 1ps

package wct_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int XW             = 32;
    localparam int YW             = 32;
    localparam int SUMW           = 64;
    localparam int CFG_IDX_W      = 2;

    localparam logic [SUMW-1:0] SAT_MAX = {1'b0, {(SUMW-1){1'b1}}};
    localparam logic [SUMW-1:0] SAT_MIN = {1'b1, {(SUMW-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW  = 2'd0,
        CFG_USE_LOW     = 2'd1,
        CFG_WINDOW_HIGH = 2'd2,
        CFG_USE_HIGH    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOW_RD,
        ST_LOW_CMP,
        ST_HIGH_RD,
        ST_HIGH_CMP,
        ST_FIRST_RD,
        ST_FIRST_OUT,
        ST_SEG_RD,
        ST_SEG_MUL,
        ST_SEG_ADD
    } state_t;

    typedef enum logic [1:0] {
        RD_LO,
        RD_HI,
        RD_IDX
    } rd_sel_t;

    typedef struct packed {
        logic    wr_point;
        logic    setup;
        logic    lo_inc;
        logic    hi_dec;
        logic    idx_load;
        logic    idx_inc;
        rd_sel_t rd_sel;
        logic    mul_en;
        logic    emit_empty;
        logic    emit_first;
        logic    emit_seg;
        logic    clear_run;
    } dp_cmd_t;

    typedef struct packed {
        logic low_hit;
        logic high_hit;
        logic lo_eq_hi;
        logic idx_eq_hi;
    } dp_status_t;

    // signed add that clamps to the 64-bit range
    function automatic logic [SUMW-1:0] sat_add(input logic [SUMW-1:0] a,
                                                input logic [SUMW-1:0] b);
        logic [SUMW-1:0] r;
        r = a + b;
        if ((a[SUMW-1] == b[SUMW-1]) && (r[SUMW-1] != a[SUMW-1]))
            r = a[SUMW-1] ? SAT_MIN : SAT_MAX;
        return r;
    endfunction

endpackage

### hw/rtl/wct_ram.sv
// generic single write port ram with registered read
// no dependencies; used for the point stores
`timescale 1ns / 1ps

module wct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/wct_datapath.sv
// datapath: point stores, window registers, trim pointers, segment area and running sum
// depends on wct_pkg and wct_ram
`timescale 1ns / 1ps

module wct_datapath #(
    parameter int MAX_POINTS = wct_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wct_pkg::dp_cmd_t              cmd,
    output wct_pkg::dp_status_t           status,
    input  logic [wct_pkg::XW-1:0]        abscissa,
    input  logic [wct_pkg::YW-1:0]        ordinate,
    input  logic                          cfg_valid,
    input  logic [wct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wct_pkg::XW-1:0]        cfg_data,
    output logic                          result_strobe,
    output logic [wct_pkg::XW-1:0]        point_x,
    output logic [wct_pkg::SUMW-1:0]      integral,
    output logic                          empty_window,
    output logic                          overflowed,
    output logic                          last_out
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = wct_pkg::XW;
    localparam int YW = wct_pkg::YW;
    localparam int SW = wct_pkg::SUMW;

    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic [XW-1:0] win_low_reg, win_high_reg;
    logic          use_low_reg, use_high_reg;

    logic [XW-1:0] prev_x_reg;
    logic [YW-1:0] prev_y_reg;
    logic [SW-1:0] half_reg;
    logic          neg_reg;
    logic [SW-1:0] sum_reg, sum_next;

    logic          strobe_reg;
    logic [XW-1:0] point_x_reg;
    logic [SW-1:0] integral_reg;
    logic          empty_reg, ovf_reg, last_reg;

    logic          full;
    logic          we;
    logic [AW-1:0] raddr;
    logic [XW-1:0] x_rd;
    logic [YW-1:0] y_rd;

    logic [YW:0]   ys;
    logic [XW:0]   dx;
    logic [YW:0]   ym;
    logic [XW:0]   dm;
    logic [YW+XW+1:0] prod;
    logic [SW-1:0] area;

    assign full = (count_reg == CW'(MAX_POINTS));
    assign we   = cmd.wr_point && !full;

    always_comb
    begin
        case (cmd.rd_sel)
            wct_pkg::RD_LO:  raddr = lo_reg;
            wct_pkg::RD_HI:  raddr = hi_reg;
            wct_pkg::RD_IDX: raddr = idx_reg;
            default:         raddr = idx_reg;
        endcase
    end

    wct_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_x_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (abscissa),
        .raddr (raddr),
        .rdata (x_rd)
    );

    wct_ram #(.WIDTH(YW), .DEPTH(MAX_POINTS)) u_y_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ordinate),
        .raddr (raddr),
        .rdata (y_rd)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg  <= '0;
            use_low_reg  <= 1'b0;
            win_high_reg <= '0;
            use_high_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (wct_pkg::cfg_idx_t'(cfg_index))
                wct_pkg::CFG_WINDOW_LOW:  win_low_reg  <= cfg_data;
                wct_pkg::CFG_USE_LOW:     use_low_reg  <= cfg_data[0];
                wct_pkg::CFG_WINDOW_HIGH: win_high_reg <= cfg_data;
                wct_pkg::CFG_USE_HIGH:    use_high_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // trim scan comparisons on the word just read
    assign status.low_hit   = use_low_reg && ($signed(x_rd) < $signed(win_low_reg))
                              && (lo_reg < hi_reg);
    assign status.high_hit  = use_high_reg && ($signed(win_high_reg) < $signed(x_rd))
                              && (hi_reg > lo_reg);
    assign status.lo_eq_hi  = (lo_reg == hi_reg);
    assign status.idx_eq_hi = (idx_reg == hi_reg);

    // segment area: (y0 + y1) * (x1 - x0) / 2 on magnitudes, sign applied later
    assign ys   = {prev_y_reg[YW-1], prev_y_reg} + {y_rd[YW-1], y_rd};
    assign dx   = {x_rd[XW-1], x_rd} - {prev_x_reg[XW-1], prev_x_reg};
    assign ym   = ys[YW] ? (YW+1)'(-ys) : ys;
    assign dm   = dx[XW] ? (XW+1)'(-dx) : dx;
    assign prod = (YW+XW+2)'(ym) * (YW+XW+2)'(dm);
    assign area = neg_reg ? SW'(-half_reg) : half_reg;

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        if (cmd.wr_point)
        begin
            if (full)
                drop_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
        end
        if (cmd.setup)
        begin
            lo_next = '0;
            hi_next = AW'(count_reg - 1'b1);
        end
        if (cmd.lo_inc)
            lo_next = lo_reg + 1'b1;
        if (cmd.hi_dec)
            hi_next = hi_reg - 1'b1;
        if (cmd.idx_load)
            idx_next = lo_reg;
        if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
        if (cmd.emit_first)
            sum_next = '0;
        if (cmd.emit_seg)
            sum_next = wct_pkg::sat_add(sum_reg, area);
        if (cmd.clear_run)
        begin
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            sum_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            sum_reg    <= sum_next;
            strobe_reg <= cmd.emit_empty || cmd.emit_first || cmd.emit_seg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        if (cmd.mul_en)
        begin
            half_reg <= prod[SW:1];
            neg_reg  <= ys[YW] ^ dx[XW];
        end
        if (cmd.mul_en || cmd.emit_first)
        begin
            prev_x_reg <= x_rd;
            prev_y_reg <= y_rd;
        end
        if (cmd.emit_empty)
        begin
            point_x_reg  <= '0;
            integral_reg <= '0;
            empty_reg    <= 1'b1;
            ovf_reg      <= drop_reg;
            last_reg     <= 1'b1;
        end
        else if (cmd.emit_first)
        begin
            point_x_reg  <= x_rd;
            integral_reg <= '0;
            empty_reg    <= 1'b0;
            ovf_reg      <= drop_reg;
            last_reg     <= 1'b0;
        end
        else if (cmd.emit_seg)
        begin
            point_x_reg  <= prev_x_reg;
            integral_reg <= sum_next;
            empty_reg    <= 1'b0;
            ovf_reg      <= drop_reg;
            last_reg     <= status.idx_eq_hi;
        end
    end

    assign result_strobe = strobe_reg;
    assign point_x       = point_x_reg;
    assign integral      = integral_reg;
    assign empty_window  = empty_reg;
    assign overflowed    = ovf_reg;
    assign last_out      = last_reg;

endmodule

### hw/rtl/wct_ctrl.sv
// controller: load, trim scans and emission sequencing
// depends on wct_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "windowed_cumulative_trapezoid_unit_defines.svh"

module wct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                final_point,
    output logic                busy,
    input  wct_pkg::dp_status_t status,
    output wct_pkg::dp_cmd_t    cmd
);

    wct_pkg::state_t state_reg, state_next;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wct_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy   = (state_reg != wct_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = wct_pkg::RD_IDX;
        case (state_reg)
            wct_pkg::ST_IDLE:
            begin
                cmd.wr_point = accept;
                if (accept && final_point)
                    state_next = wct_pkg::ST_SETUP;
            end
            wct_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = wct_pkg::ST_LOW_RD;
            end
            wct_pkg::ST_LOW_RD:
            begin
                cmd.rd_sel = wct_pkg::RD_LO;
                state_next = wct_pkg::ST_LOW_CMP;
            end
            wct_pkg::ST_LOW_CMP:
            begin
                if (status.low_hit)
                begin
                    cmd.lo_inc = 1'b1;
                    state_next = wct_pkg::ST_LOW_RD;
                end
                else
                    state_next = wct_pkg::ST_HIGH_RD;
            end
            wct_pkg::ST_HIGH_RD:
            begin
                cmd.rd_sel = wct_pkg::RD_HI;
                state_next = wct_pkg::ST_HIGH_CMP;
            end
            wct_pkg::ST_HIGH_CMP:
            begin
                if (status.high_hit)
                begin
                    cmd.hi_dec = 1'b1;
                    state_next = wct_pkg::ST_HIGH_RD;
                end
                else if (status.lo_eq_hi)
                begin
                    // single point left: one empty-window result ends the run
                    cmd.emit_empty = 1'b1;
                    cmd.clear_run  = 1'b1;
                    state_next     = wct_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.idx_load = 1'b1;
                    state_next   = wct_pkg::ST_FIRST_RD;
                end
            end
            wct_pkg::ST_FIRST_RD:
            begin
                state_next = wct_pkg::ST_FIRST_OUT;
            end
            wct_pkg::ST_FIRST_OUT:
            begin
                cmd.emit_first = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = wct_pkg::ST_SEG_RD;
            end
            wct_pkg::ST_SEG_RD:
            begin
                state_next = wct_pkg::ST_SEG_MUL;
            end
            wct_pkg::ST_SEG_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = wct_pkg::ST_SEG_ADD;
            end
            wct_pkg::ST_SEG_ADD:
            begin
                cmd.emit_seg = 1'b1;
                if (status.idx_eq_hi)
                begin
                    cmd.clear_run = 1'b1;
                    state_next    = wct_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = wct_pkg::ST_SEG_RD;
                end
            end
            default:
            begin
                state_next = wct_pkg::ST_IDLE;
            end
        endcase
    end

    `WCT_ASSERT_IMP(a_emit_onehot, clk, rst_n, 1'b1, $onehot0({cmd.emit_empty, cmd.emit_first, cmd.emit_seg}), "more than one result command in a cycle")
    `WCT_ASSERT_NEXT(a_final_starts_run, clk, rst_n, start && !busy && final_point, busy, "final point did not start a run")
    `WCT_ASSERT_NEXT(a_mul_then_add, clk, rst_n, state_reg == wct_pkg::ST_SEG_MUL, cmd.emit_seg, "segment product not followed by its result")
    `WCT_ASSERT_IMP(a_no_store_in_run, clk, rst_n, busy, !cmd.wr_point && !(cmd.clear_run && cmd.setup), "point store touched during a run")

endmodule

### hw/rtl/windowed_cumulative_trapezoid_unit.sv
// top level of the windowed cumulative trapezoid integrator
// depends on wct_pkg, wct_ctrl, wct_datapath (and wct_ram below it)
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  input    | start & !busy              | abscissa, ordinate, final_point
//  config   | cfg_valid & cfg_ready      | cfg_index, cfg_data
//  result   | result_strobe (one cycle)  | point_x, integral, empty_window,
//           |                            | overflowed, last_out
//
// a non-final point is taken and busy stays low
// after the final point the run sets up the trim pointers, scans each end with a
// read and a compare per point, emits the first kept point, then reads, multiplies
// and adds each further one, paced by the single read port and registered multiplier
// reset clears the run state and window registers; the stores need no clearing
// results cannot be stalled; a new curve may load while the last result is shown
`timescale 1ns / 1ps

module windowed_cumulative_trapezoid_unit #(
    parameter int MAX_POINTS = wct_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [wct_pkg::XW-1:0]        abscissa,
    input  logic [wct_pkg::YW-1:0]        ordinate,
    input  logic                          final_point,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wct_pkg::XW-1:0]        cfg_data,
    output logic                          result_strobe,
    output logic [wct_pkg::XW-1:0]        point_x,
    output logic [wct_pkg::SUMW-1:0]      integral,
    output logic                          empty_window,
    output logic                          overflowed,
    output logic                          last_out
);

    wct_pkg::dp_cmd_t    cmd;
    wct_pkg::dp_status_t status;

    // window registers take a write in any cycle
    assign cfg_ready = 1'b1;

    wct_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .final_point (final_point),
        .busy        (busy),
        .status      (status),
        .cmd         (cmd)
    );

    wct_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .abscissa      (abscissa),
        .ordinate      (ordinate),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .point_x       (point_x),
        .integral      (integral),
        .empty_window  (empty_window),
        .overflowed    (overflowed),
        .last_out      (last_out)
    );

endmodule
